/* sv/bawc_pkg.sv */
// Shared constants and types for the bond angle window check.
// No dependencies; imported by bond_angle_window_check.
`default_nettype none

package bawc_pkg;

  // Fixed field widths
  localparam int POS_W = 63;  // packed x,y,z position
  localparam int CFG_W = 16;  // widest config register
  localparam int CFG_IDX_W = 1;

  // Default coordinate width
  localparam int COORD_BITS_DEF = 21;

  // Q2.14 bounds: fraction bits and width of a squared bound
  localparam int Q_FRAC = 14;
  localparam int CSQ_W = 2 * CFG_W - 1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_COS_LOWER = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COS_UPPER = 1'd1;

  // Reset values
  localparam logic signed [CFG_W-1:0] COS_LOWER_RST = -16'sd16384;
  localparam logic signed [CFG_W-1:0] COS_UPPER_RST = 16'sd16384;

  // Per-angle status carried down the pipeline
  typedef struct packed {
    logic neg;    // dot product negative
    logic dzero;  // dot product zero
    logic nzero;  // one of the two vectors has zero length
  } ang_flags_t;

endpackage

`default_nettype wire

/* sv/bond_angle_window_check.sv */
// Bond angle window check: top level, full nine-stage datapath.
// Depends on bawc_pkg.
`default_nettype none

// Checks whether a bond between atoms A and B may form. For each atom that
// has a neighbor, the cosine of the angle between (atom - partner) and
// (atom - neighbor) must lie in [cos_lower, cos_upper] (Q2.14); the test is
// exact, done on squared terms with no rounding, and a zero-length vector
// fails. Throughput is one transfer per cycle unless out_ready stalls it.
// The first of nine register stages loads at the input transfer edge and the
// result is valid once the ninth loads. Depth is set by the multiplier chain:
// differences, 22x22 coordinate products, their sums, magnitude, 22x22
// partial products of |n1|*|n2| and dot^2, their sums, 22x31 partials
// against the squared bounds, their sums, and the final compare. Each stage
// holds its item under backpressure and fills any bubble ahead of it.
// Bounds are written through cfg_write/cfg_index/cfg_data; the user must write them only while idle (not enforced).
module bond_angle_window_check
  import bawc_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  wire                        clk,
  input  wire                        rst,
  input  wire                        cfg_write,
  input  wire        [CFG_IDX_W-1:0] cfg_index,
  input  wire        [CFG_W-1:0]     cfg_data,
  input  wire                        in_valid,
  output logic                       in_ready,
  input  wire        [POS_W-1:0]     pos_a,
  input  wire        [POS_W-1:0]     pos_b,
  input  wire        [POS_W-1:0]     neighbor_of_a,
  input  wire        [POS_W-1:0]     neighbor_of_b,
  input  wire                        a_has_neighbor,
  input  wire                        b_has_neighbor,
  output logic                       out_valid,
  input  wire                        out_ready,
  output logic                       bond_allowed
);

  localparam int CB  = COORD_BITS;
  localparam int DW  = CB + 1;          // coordinate difference
  localparam int QW  = 2 * CB;          // one squared difference
  localparam int SW  = 2 * DW + 2;      // signed dot product
  localparam int NW  = 2 * CB + 2;      // squared length, |dot|
  localparam int HW  = NW / 2;          // half of NW
  localparam int PW  = 2 * NW;          // n1*n2, dot^2
  localparam int CW  = HW + CSQ_W;      // partial against squared bound
  localparam int FW  = PW + CSQ_W;      // compare width
  localparam int NS  = 9;               // pipeline stages

  // ---------------- configuration ----------------
  logic signed [CFG_W-1:0] cos_lower, cos_upper;
  logic signed [2*CFG_W-1:0] lo_sq_full, up_sq_full;
  logic [CSQ_W-1:0] cos_lower_sq, cos_upper_sq;

  always_ff @(posedge clk) begin
    if (rst) begin
      cos_lower <= COS_LOWER_RST;
      cos_upper <= COS_UPPER_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_COS_LOWER: cos_lower <= cfg_data;
        REG_COS_UPPER: cos_upper <= cfg_data;
        default: ;
      endcase
    end
  end

  assign lo_sq_full = cos_lower * cos_lower;
  assign up_sq_full = cos_upper * cos_upper;

  always_ff @(posedge clk) begin
    cos_lower_sq <= lo_sq_full[CSQ_W-1:0];
    cos_upper_sq <= up_sq_full[CSQ_W-1:0];
  end

  // ---------------- pipeline control ----------------
  logic [NS-1:0] v;
  logic [NS-1:0] en;
  logic [1:0]    has [NS];

  always_comb begin
    en[NS-1] = !v[NS-1] || out_ready;
    for (int i = NS - 2; i >= 0; i--) begin
      en[i] = !v[i] || en[i+1];
    end
  end

  // no transfer is taken while reset is held
  assign in_ready  = en[0] && !rst;
  assign out_valid = v[NS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) v[0] <= in_valid;
      for (int i = 1; i < NS; i++) begin
        if (en[i]) v[i] <= v[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) has[0] <= {b_has_neighbor, a_has_neighbor};
    for (int i = 1; i < NS; i++) begin
      if (en[i]) has[i] <= has[i-1];
    end
  end

  // ---------------- stage 1: differences ----------------
  // angle 0 sits at A (partner B), angle 1 at B (partner A)
  logic [POS_W-1:0] p_self [2];
  logic [POS_W-1:0] p_part [2];
  logic [POS_W-1:0] p_nbr  [2];

  assign p_self[0] = pos_a;
  assign p_part[0] = pos_b;
  assign p_nbr[0]  = neighbor_of_a;
  assign p_self[1] = pos_b;
  assign p_part[1] = pos_a;
  assign p_nbr[1]  = neighbor_of_b;

  logic signed [DW-1:0] d1_c [2][3];
  logic signed [DW-1:0] d2_c [2][3];
  logic signed [DW-1:0] s1_d1 [2][3];
  logic signed [DW-1:0] s1_d2 [2][3];

  always_comb begin
    for (int j = 0; j < 2; j++) begin
      for (int k = 0; k < 3; k++) begin
        d1_c[j][k] = DW'($signed(p_self[j][k*CB +: CB]))
                   - DW'($signed(p_part[j][k*CB +: CB]));
        d2_c[j][k] = DW'($signed(p_self[j][k*CB +: CB]))
                   - DW'($signed(p_nbr[j][k*CB +: CB]));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s1_d1 <= d1_c;
      s1_d2 <= d2_c;
    end
  end

  // ---------------- stage 2: coordinate products ----------------
  logic signed [2*DW-1:0] s2_pd [2][3];
  logic        [QW-1:0]   s2_q1 [2][3];
  logic        [QW-1:0]   s2_q2 [2][3];
  logic signed [2*DW-1:0] sq1_c [2][3];
  logic signed [2*DW-1:0] sq2_c [2][3];

  always_comb begin
    for (int j = 0; j < 2; j++) begin
      for (int k = 0; k < 3; k++) begin
        sq1_c[j][k] = s1_d1[j][k] * s1_d1[j][k];
        sq2_c[j][k] = s1_d2[j][k] * s1_d2[j][k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      for (int j = 0; j < 2; j++) begin
        for (int k = 0; k < 3; k++) begin
          s2_pd[j][k] <= s1_d1[j][k] * s1_d2[j][k];
          s2_q1[j][k] <= sq1_c[j][k][QW-1:0];
          s2_q2[j][k] <= sq2_c[j][k][QW-1:0];
        end
      end
    end
  end

  // ---------------- stage 3: dot product and squared lengths ----------------
  logic signed [SW-1:0] s3_dot [2];
  logic        [NW-1:0] s3_n1  [2];
  logic        [NW-1:0] s3_n2  [2];

  always_ff @(posedge clk) begin
    if (en[2]) begin
      for (int j = 0; j < 2; j++) begin
        s3_dot[j] <= SW'(s2_pd[j][0]) + SW'(s2_pd[j][1]) + SW'(s2_pd[j][2]);
        s3_n1[j]  <= NW'(s2_q1[j][0]) + NW'(s2_q1[j][1]) + NW'(s2_q1[j][2]);
        s3_n2[j]  <= NW'(s2_q2[j][0]) + NW'(s2_q2[j][1]) + NW'(s2_q2[j][2]);
      end
    end
  end

  // ---------------- stage 4: magnitude and zero flags ----------------
  logic [NW-1:0]  s4_ad [2];
  logic [NW-1:0]  s4_n1 [2];
  logic [NW-1:0]  s4_n2 [2];
  ang_flags_t     s4_fl [2];
  logic [SW-1:0]  abs_c [2];

  always_comb begin
    for (int j = 0; j < 2; j++) begin
      abs_c[j] = s3_dot[j][SW-1] ? SW'(-s3_dot[j]) : SW'(s3_dot[j]);
    end
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      for (int j = 0; j < 2; j++) begin
        s4_ad[j]       <= abs_c[j][NW-1:0];
        s4_n1[j]       <= s3_n1[j];
        s4_n2[j]       <= s3_n2[j];
        s4_fl[j].neg   <= s3_dot[j][SW-1];
        s4_fl[j].dzero <= (s3_dot[j] == '0);
        s4_fl[j].nzero <= (s3_n1[j] == '0) || (s3_n2[j] == '0);
      end
    end
  end

  // ---------------- stage 5: partial products ----------------
  logic [2*HW-1:0] s5_pp [2][4];  // n1*n2: hh, hl, lh, ll
  logic [2*HW-1:0] s5_ap [2][3];  // ad^2: hh, hl, ll
  ang_flags_t      s5_fl [2];

  always_ff @(posedge clk) begin
    if (en[4]) begin
      for (int j = 0; j < 2; j++) begin
        s5_pp[j][0] <= s4_n1[j][NW-1:HW] * s4_n2[j][NW-1:HW];
        s5_pp[j][1] <= s4_n1[j][NW-1:HW] * s4_n2[j][HW-1:0];
        s5_pp[j][2] <= s4_n1[j][HW-1:0]  * s4_n2[j][NW-1:HW];
        s5_pp[j][3] <= s4_n1[j][HW-1:0]  * s4_n2[j][HW-1:0];
        s5_ap[j][0] <= s4_ad[j][NW-1:HW] * s4_ad[j][NW-1:HW];
        s5_ap[j][1] <= s4_ad[j][NW-1:HW] * s4_ad[j][HW-1:0];
        s5_ap[j][2] <= s4_ad[j][HW-1:0]  * s4_ad[j][HW-1:0];
        s5_fl[j]    <= s4_fl[j];
      end
    end
  end

  // ---------------- stage 6: n1*n2 and dot^2 ----------------
  logic [PW-1:0] s6_p   [2];
  logic [PW-1:0] s6_asq [2];
  ang_flags_t    s6_fl  [2];

  always_ff @(posedge clk) begin
    if (en[5]) begin
      for (int j = 0; j < 2; j++) begin
        s6_p[j]   <= (PW'(s5_pp[j][0]) << (2 * HW))
                   + ((PW'(s5_pp[j][1]) + PW'(s5_pp[j][2])) << HW)
                   + PW'(s5_pp[j][3]);
        s6_asq[j] <= (PW'(s5_ap[j][0]) << (2 * HW))
                   + (PW'(s5_ap[j][1]) << (HW + 1))
                   + PW'(s5_ap[j][2]);
        s6_fl[j]  <= s5_fl[j];
      end
    end
  end

  // ---------------- stage 7: partials against squared bounds ----------------
  logic [CW-1:0] s7_plo [2][4];
  logic [CW-1:0] s7_pup [2][4];
  logic [PW-1:0] s7_asq [2];
  ang_flags_t    s7_fl  [2];

  always_ff @(posedge clk) begin
    if (en[6]) begin
      for (int j = 0; j < 2; j++) begin
        for (int i = 0; i < 4; i++) begin
          s7_plo[j][i] <= CW'(s6_p[j][i*HW +: HW]) * CW'(cos_lower_sq);
          s7_pup[j][i] <= CW'(s6_p[j][i*HW +: HW]) * CW'(cos_upper_sq);
        end
        s7_asq[j] <= s6_asq[j];
        s7_fl[j]  <= s6_fl[j];
      end
    end
  end

  // ---------------- stage 8: bound products, scaled dot^2 ----------------
  logic [FW-1:0] s8_plo [2];
  logic [FW-1:0] s8_pup [2];
  logic [FW-1:0] s8_dsq [2];
  ang_flags_t    s8_fl  [2];
  logic [FW-1:0] plo_c  [2];
  logic [FW-1:0] pup_c  [2];

  always_comb begin
    for (int j = 0; j < 2; j++) begin
      plo_c[j] = '0;
      pup_c[j] = '0;
      for (int i = 0; i < 4; i++) begin
        plo_c[j] = plo_c[j] + (FW'(s7_plo[j][i]) << (i * HW));
        pup_c[j] = pup_c[j] + (FW'(s7_pup[j][i]) << (i * HW));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[7]) begin
      for (int j = 0; j < 2; j++) begin
        s8_plo[j] <= plo_c[j];
        s8_pup[j] <= pup_c[j];
        s8_dsq[j] <= FW'(s7_asq[j]) << (2 * Q_FRAC);
        s8_fl[j]  <= s7_fl[j];
      end
    end
  end

  // ---------------- stage 9: window compare, result register ----------------
  logic [1:0] ang_ok;
  logic       lower_ok, upper_ok;
  logic       ok_c;

  always_comb begin
    ang_ok = '0;
    for (int j = 0; j < 2; j++) begin
      // cos >= lower: sign of the bound decides direction of the square test
      if (!cos_lower[CFG_W-1]) lower_ok = !s8_fl[j].neg && (s8_dsq[j] >= s8_plo[j]);
      else                     lower_ok = !s8_fl[j].neg || (s8_dsq[j] <= s8_plo[j]);
      if (!cos_upper[CFG_W-1]) begin
        upper_ok = s8_fl[j].neg || s8_fl[j].dzero || (s8_dsq[j] <= s8_pup[j]);
      end else begin
        upper_ok = s8_fl[j].neg && (s8_dsq[j] >= s8_pup[j]);
      end
      ang_ok[j] = !s8_fl[j].nzero && lower_ok && upper_ok;
    end
    ok_c = (!has[NS-2][0] || ang_ok[0]) && (!has[NS-2][1] || ang_ok[1]);
  end

  always_ff @(posedge clk) begin
    if (en[NS-1]) bond_allowed <= ok_c;
  end

endmodule

`default_nettype wire
